FILE: rtl/core/remote_id_frame_element_finder_macros.svh
// Assertion macros shared by the frame element finder RTL.
`ifndef REMOTE_ID_FRAME_ELEMENT_FINDER_MACROS_SVH
`define REMOTE_ID_FRAME_ELEMENT_FINDER_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define RIDEF_ASSERT_CLK(label, clock, resetn, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) prop) \
        else $error(msg);

// Concurrent assertion on the block clock clk and reset rst_n.
`define RIDEF_ASSERT(label, prop, msg) \
    `RIDEF_ASSERT_CLK(label, clk, rst_n, prop, msg)

`endif

FILE: rtl/core/ridef_pkg.sv
// Package with types and constants of the frame element finder.
`default_nettype none

package ridef_pkg;

    localparam int MAX_FRAME_DEFAULT = 4096;

    localparam logic [5:0]  START_OFFSET_RESET = 6'd24;
    localparam logic [23:0] VENDOR_OUI_RESET   = 24'hFFFF5F;
    localparam logic [7:0]  ACT_CATEGORY_RESET = 8'h0D;
    localparam logic [31:0] ACT_ID_RESET       = 32'h506F9A13;

    localparam logic [7:0] VENDOR_ELEM_ID = 8'd221;
    localparam logic [7:0] VENDOR_MIN_LEN = 8'd5;

    localparam logic [3:0] SUB_PROBE_RESP = 4'd5;
    localparam logic [3:0] SUB_BEACON     = 4'd8;
    localparam logic [3:0] SUB_ACTION     = 4'd13;

    localparam int ACT_CAT_POS       = 4;
    localparam int ACT_LAST_POS      = 8;
    localparam int ACT_ELEMENT_START = 9;
    localparam int ADDR_FIRST_POS    = 10;
    localparam int ADDR_LAST_POS     = 15;

    localparam int TDATA_IN_W  = 8;
    localparam int TUSER_IN_W  = 2;
    localparam int TDATA_OUT_W = 72;

    typedef enum logic [1:0] {
        REG_START_OFFSET = 2'd0,
        REG_VENDOR_OUI   = 2'd1,
        REG_ACT_CATEGORY = 2'd2,
        REG_ACT_ID       = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        PATH_NONE    = 2'd0,
        PATH_BEACON  = 2'd1,
        PATH_ACTION  = 2'd2,
        PATH_PENDING = 2'd3
    } path_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_ID   = 3'd1,
        PH_LEN  = 3'd2,
        PH_OUI1 = 3'd3,
        PH_OUI2 = 3'd4,
        PH_OUI3 = 3'd5,
        PH_PAY  = 3'd6,
        PH_SKIP = 3'd7
    } phase_t;

endpackage

`default_nettype wire

FILE: rtl/core/remote_id_frame_element_finder.sv
// The result item is registered on the accepted last byte and is on m_tvalid the next cycle.
// One byte item per cycle while s_tready is high; the parse state is registered per byte.
// Input is stalled only while a result item waits and m_tready is low.
// Reset is asynchronous, active low; it clears the frame state and the result valid flag
// and loads the configuration registers with their defaults.
`default_nettype none
`include "remote_id_frame_element_finder_macros.svh"

module remote_id_frame_element_finder #(
    parameter int MAX_FRAME = ridef_pkg::MAX_FRAME_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // Fields from bit 0: data_byte[7:0].
    input  wire logic [ridef_pkg::TDATA_IN_W-1:0] s_tdata,
    input  wire logic                             s_tlast,
    // Fields from bit 0: first_byte[0], is_management[1].
    input  wire logic [ridef_pkg::TUSER_IN_W-1:0] s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // Fields from bit 0: found[0], frame_path[2:1], message_type[6:3],
    // payload_offset[18:7], source_address[66:19], zero fill[71:67].
    output logic [ridef_pkg::TDATA_OUT_W-1:0]     m_tdata,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [3:0]                       paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import ridef_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME + 1);
    localparam logic [POS_W-1:0] POS_MAX   = POS_W'(MAX_FRAME);
    localparam logic [POS_W-1:0] POS_CAT   = POS_W'(ACT_CAT_POS);
    localparam logic [POS_W-1:0] POS_ACT   = POS_W'(ACT_LAST_POS);
    localparam logic [POS_W-1:0] POS_AFIRST = POS_W'(ADDR_FIRST_POS);
    localparam logic [POS_W-1:0] POS_ALAST = POS_W'(ADDR_LAST_POS);
    localparam logic [POS_W-1:0] POS_ASTART = POS_W'(ACT_ELEMENT_START);

    logic [5:0]  start_off_reg;
    logic [23:0] vendor_oui_reg;
    logic [7:0]  act_cat_reg;
    logic [31:0] act_id_reg;

    logic [POS_W-1:0] pos_reg, pos_next;
    path_t            path_reg, path_next;
    logic             act_reg, act_next;
    phase_t           phase_reg, phase_next;
    logic [7:0]       rem_reg, rem_next;
    logic             cand_reg, cand_next;
    logic [47:0]      addr_reg, addr_next;
    logic             hit_reg, hit_next;
    logic [3:0]       htype_reg, htype_next;
    logic [11:0]      hoff_reg, hoff_next;

    logic                   out_valid_reg, out_valid_next;
    logic [TDATA_OUT_W-1:0] out_data_reg, out_data_next;

    logic       s_fire;
    logic       cfg_write;
    logic [7:0] b;
    logic       first_b;
    logic       mgmt;

    logic [POS_W-1:0] p;
    path_t            cur_path;
    logic             cur_act;
    phase_t           cur_phase;
    logic [7:0]       cur_rem;
    logic             cur_cand;
    logic [47:0]      cur_addr;
    logic             cur_hit;
    logic [3:0]       cur_htype;
    logic [11:0]      cur_hoff;

    logic [7:0]       act_want;
    logic             act_ok;
    logic [POS_W-1:0] walk_start;
    phase_t           ph_eff;
    logic [7:0]       oui_want;
    logic [7:0]       rem_dec;
    logic [47:0]      addr_out;
    logic [1:0]       path_out;

    assign b        = s_tdata[7:0];
    assign first_b  = s_tuser[0];
    assign mgmt     = s_tuser[1];
    assign s_tready = !out_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign pready   = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_START_OFFSET: prdata = {26'd0, start_off_reg};
            REG_VENDOR_OUI:   prdata = {8'd0, vendor_oui_reg};
            REG_ACT_CATEGORY: prdata = {24'd0, act_cat_reg};
            REG_ACT_ID:       prdata = act_id_reg;
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_off_reg  <= START_OFFSET_RESET;
            vendor_oui_reg <= VENDOR_OUI_RESET;
            act_cat_reg    <= ACT_CATEGORY_RESET;
            act_id_reg     <= ACT_ID_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_START_OFFSET: start_off_reg  <= pwdata[5:0];
                REG_VENDOR_OUI:   vendor_oui_reg <= pwdata[23:0];
                REG_ACT_CATEGORY: act_cat_reg    <= pwdata[7:0];
                REG_ACT_ID:       act_id_reg     <= pwdata;
                default:          act_id_reg     <= act_id_reg;
            endcase
        end
    end

    // A first byte restarts the frame state before this byte is parsed.
    always_comb
    begin
        p         = first_b ? '0 : pos_reg;
        cur_path  = first_b ? PATH_NONE : path_reg;
        cur_act   = first_b ? 1'b0 : act_reg;
        cur_phase = first_b ? PH_IDLE : phase_reg;
        cur_rem   = first_b ? 8'd0 : rem_reg;
        cur_cand  = first_b ? 1'b0 : cand_reg;
        cur_addr  = first_b ? 48'd0 : addr_reg;
        cur_hit   = first_b ? 1'b0 : hit_reg;
        cur_htype = first_b ? 4'd0 : htype_reg;
        cur_hoff  = first_b ? 12'd0 : hoff_reg;
    end

    always_comb
    begin
        pos_next   = p;
        path_next  = cur_path;
        act_next   = cur_act;
        phase_next = cur_phase;
        rem_next   = cur_rem;
        cand_next  = cur_cand;
        addr_next  = cur_addr;
        hit_next   = cur_hit;
        htype_next = cur_htype;
        hoff_next  = cur_hoff;

        case (p[3:0])
            4'd5:    act_want = act_id_reg[31:24];
            4'd6:    act_want = act_id_reg[23:16];
            4'd7:    act_want = act_id_reg[15:8];
            4'd8:    act_want = act_id_reg[7:0];
            default: act_want = act_cat_reg;
        endcase
        act_ok = (b == act_want);

        case (cur_phase)
            PH_OUI1: oui_want = vendor_oui_reg[23:16];
            PH_OUI2: oui_want = vendor_oui_reg[15:8];
            default: oui_want = vendor_oui_reg[7:0];
        endcase
        rem_dec = cur_rem - 8'd1;

        walk_start = '0;
        ph_eff     = PH_IDLE;

        if (p == POS_MAX)
        begin
            hit_next   = 1'b0;
            htype_next = 4'd0;
            hoff_next  = 12'd0;
        end
        else
        begin
            if (p == '0)
            begin
                if (!mgmt)
                    path_next = PATH_NONE;
                else if (b[7:4] == SUB_BEACON || b[7:4] == SUB_PROBE_RESP)
                    path_next = PATH_BEACON;
                else if (b[7:4] == SUB_ACTION)
                    path_next = PATH_PENDING;
                else
                    path_next = PATH_NONE;
            end
            else if (cur_path == PATH_PENDING && p >= POS_CAT && p <= POS_ACT)
            begin
                act_next = (p == POS_CAT) ? act_ok : (cur_act && act_ok);
                if (!act_next)
                    path_next = PATH_NONE;
                else if (p == POS_ACT)
                    path_next = PATH_ACTION;
            end

            if (p >= POS_AFIRST && p <= POS_ALAST)
                addr_next = {cur_addr[39:0], b};

            walk_start = (path_next == PATH_BEACON) ? POS_W'(start_off_reg) : POS_ASTART;
            if (cur_phase == PH_IDLE)
                ph_eff = (p == walk_start) ? PH_ID : PH_IDLE;
            else
                ph_eff = cur_phase;

            if ((path_next == PATH_BEACON || path_next == PATH_ACTION) && !cur_hit)
            begin
                case (ph_eff)
                    PH_IDLE:
                    begin
                        phase_next = PH_IDLE;
                    end
                    PH_ID:
                    begin
                        cand_next  = (b == VENDOR_ELEM_ID);
                        phase_next = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        rem_next = b;
                        if (cur_cand && b >= VENDOR_MIN_LEN)
                            phase_next = PH_OUI1;
                        else
                            phase_next = (b == 8'd0) ? PH_ID : PH_SKIP;
                    end
                    PH_PAY:
                    begin
                        hit_next   = 1'b1;
                        htype_next = b[3:0];
                        hoff_next  = 12'(p);
                    end
                    PH_SKIP:
                    begin
                        rem_next = rem_dec;
                        if (rem_dec == 8'd0)
                            phase_next = PH_ID;
                    end
                    default:
                    begin
                        rem_next = rem_dec;
                        if (b != oui_want)
                            phase_next = (rem_dec == 8'd0) ? PH_ID : PH_SKIP;
                        else if (cur_phase == PH_OUI1)
                            phase_next = PH_OUI2;
                        else if (cur_phase == PH_OUI2)
                            phase_next = PH_OUI3;
                        else
                            phase_next = PH_PAY;
                    end
                endcase
            end

            pos_next = p + POS_W'(1);
        end
    end

    // Short frames leave the address right-aligned; move it to the top bytes.
    always_comb
    begin
        if (p < POS_AFIRST)
            addr_out = 48'd0;
        else if (p > POS_ALAST)
            addr_out = addr_next;
        else
        begin
            case (p[3:0])
                4'd10:   addr_out = addr_next << 40;
                4'd11:   addr_out = addr_next << 32;
                4'd12:   addr_out = addr_next << 24;
                4'd13:   addr_out = addr_next << 16;
                4'd14:   addr_out = addr_next << 8;
                default: addr_out = addr_next;
            endcase
        end

        path_out = (path_next == PATH_BEACON || path_next == PATH_ACTION) ?
                   path_next : PATH_NONE;

        out_data_next = {5'd0, addr_out,
                         hit_next ? hoff_next : 12'd0,
                         hit_next ? htype_next : 4'd0,
                         path_out, hit_next};
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s_fire && s_tlast)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire && s_tlast)
            out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            path_reg  <= PATH_NONE;
            act_reg   <= 1'b0;
            phase_reg <= PH_IDLE;
            rem_reg   <= 8'd0;
            cand_reg  <= 1'b0;
            addr_reg  <= 48'd0;
            hit_reg   <= 1'b0;
            htype_reg <= 4'd0;
            hoff_reg  <= 12'd0;
        end
        else if (s_fire)
        begin
            if (s_tlast)
            begin
                pos_reg   <= '0;
                path_reg  <= PATH_NONE;
                act_reg   <= 1'b0;
                phase_reg <= PH_IDLE;
                rem_reg   <= 8'd0;
                cand_reg  <= 1'b0;
                addr_reg  <= 48'd0;
                hit_reg   <= 1'b0;
                htype_reg <= 4'd0;
                hoff_reg  <= 12'd0;
            end
            else
            begin
                pos_reg   <= pos_next;
                path_reg  <= path_next;
                act_reg   <= act_next;
                phase_reg <= phase_next;
                rem_reg   <= rem_next;
                cand_reg  <= cand_next;
                addr_reg  <= addr_next;
                hit_reg   <= hit_next;
                htype_reg <= htype_next;
                hoff_reg  <= hoff_next;
            end
        end
    end

    `RIDEF_ASSERT(a_pos_bounded, pos_reg <= POS_MAX, "byte position beyond the frame limit")
    `RIDEF_ASSERT(a_hit_needs_path,
        hit_reg |-> (path_reg == PATH_BEACON || path_reg == PATH_ACTION),
        "hit without a qualifying path")
    `RIDEF_ASSERT(a_walk_needs_path,
        (phase_reg != PH_IDLE) |-> (path_reg == PATH_BEACON || path_reg == PATH_ACTION),
        "element walk without a qualifying path")
    `RIDEF_ASSERT(a_last_clears,
        (s_fire && s_tlast) |=> (pos_reg == '0 && !hit_reg && out_valid_reg),
        "last byte did not close the frame")
    `RIDEF_ASSERT(a_miss_fields_zero,
        (out_valid_reg && !out_data_reg[0]) |-> (out_data_reg[18:3] == 16'd0),
        "result without a hit carries hit fields")

endmodule

`default_nettype wire
